### design/grid_color_histogram_assert.svh
// Assertion macros used by the grid color histogram top level.
`ifndef GRID_COLOR_HISTOGRAM_ASSERT_SVH
`define GRID_COLOR_HISTOGRAM_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define GCH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define GCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/gch_pkg.sv
// Package with the shared constants and types of the grid color histogram.
package gch_pkg;

  // Default values of the top-level parameters.
  localparam int LEVELS_DEFAULT   = 4;
  localparam int MAX_GRID_DEFAULT = 4;
  localparam int MAX_SIZE_DEFAULT = 256;

  // Fixed widths of the fields and of the histogram store.
  localparam int STORE_DEPTH = 1024;
  localparam int BIN_W       = 10;
  localparam int COUNT_W     = 17;
  localparam int SIZE_W      = 9;
  localparam int GRID_REG_W  = 3;
  localparam int GRID_W      = 4;
  localparam int DIV_CNT_W   = 4;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam logic [COUNT_W-1:0] BIN_MAX = COUNT_W'(65536);

  // Reset values of the configuration registers.
  localparam logic [SIZE_W-1:0]     IMAGE_SIZE_RESET = SIZE_W'(64);
  localparam logic [GRID_REG_W-1:0] GRID_COUNT_RESET = GRID_REG_W'(1);

  // Operation codes of an input item.
  localparam logic [1:0] OP_ACCUMULATE = 2'd0;
  localparam logic [1:0] OP_READ       = 2'd1;
  localparam logic [1:0] OP_READ_CLEAR = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_IMAGE_SIZE = 1'b0;
  localparam logic REG_GRID_COUNT = 1'b1;

  // Crop geometry handed from the geometry unit to the datapath.
  typedef struct packed {
    logic              busy;
    logic [SIZE_W-1:0] size;
    logic [GRID_W-1:0] grid;
    logic [SIZE_W-1:0] cell_sz;
    logic [SIZE_W-1:0] crop_lo;
    logic [SIZE_W-1:0] crop_hi;
  } geom_t;

endpackage

### design/gch_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gch_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/gch_geom.sv
// Crop geometry unit: divides the image size by the grid count one bit a cycle.
module gch_geom import gch_pkg::*; #(
  parameter int MAX_GRID = MAX_GRID_DEFAULT,
  parameter int MAX_SIZE = MAX_SIZE_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SIZE_W-1:0]     image_size,
  input  logic [GRID_REG_W-1:0] grid_count,
  output geom_t                 geom,
  output logic [SIZE_W-1:0]     thr [MAX_GRID]
);

  localparam int PROD_W = SIZE_W + GRID_W;

  typedef enum logic [2:0] {
    G_IDLE   = 3'b001,
    G_DIVIDE = 3'b010,
    G_FINISH = 3'b100
  } gstate_t;

  gstate_t state, state_next;

  logic [SIZE_W-1:0]    eff_size;
  logic [GRID_W-1:0]    eff_grid;
  logic [SIZE_W-1:0]    dvd;
  logic [SIZE_W-1:0]    quo;
  logic [GRID_W-1:0]    rem;
  logic [GRID_W-1:0]    dvs;
  logic [SIZE_W-1:0]    size_hold;
  logic [DIV_CNT_W-1:0] cnt;
  logic [GRID_W:0]      rem_sh;
  logic                 fits;
  logic [PROD_W-1:0]    crop_prod;
  logic [SIZE_W-1:0]    crop;
  logic [SIZE_W-1:0]    lo_next;
  logic [SIZE_W-1:0]    thr_next [MAX_GRID];
  logic [SIZE_W-1:0]    cell_sz;
  logic [SIZE_W-1:0]    crop_lo;
  logic [SIZE_W-1:0]    crop_hi;

  // Clamp the configuration to the supported range.
  always_comb begin
    if (grid_count == '0) begin
      eff_grid = GRID_W'(1);
    end else if (GRID_W'(grid_count) > GRID_W'(MAX_GRID)) begin
      eff_grid = GRID_W'(MAX_GRID);
    end else begin
      eff_grid = GRID_W'(grid_count);
    end
    if (image_size > SIZE_W'(MAX_SIZE)) begin
      eff_size = SIZE_W'(MAX_SIZE);
    end else begin
      eff_size = image_size;
    end
  end

  // One restoring division step.
  assign rem_sh = {rem, dvd[SIZE_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  // Crop extent and the cell boundaries from the finished quotient.
  assign crop_prod = PROD_W'(quo) * PROD_W'(dvs);
  assign crop      = crop_prod[SIZE_W-1:0];
  assign lo_next   = (size_hold - crop) >> 1;

  always_comb begin
    logic [PROD_W-1:0] prod;
    prod = '0;
    for (int k = 0; k < MAX_GRID; k++) begin
      prod = PROD_W'(k) * PROD_W'(quo);
      if (prod > PROD_W'({SIZE_W{1'b1}})) begin
        thr_next[k] = '1;
      end else begin
        thr_next[k] = prod[SIZE_W-1:0];
      end
    end
  end

  // Sequencer of the division.
  always_comb begin
    state_next = state;
    case (state)
      G_IDLE:   state_next = G_IDLE;
      G_DIVIDE: if (cnt == '0) begin
        state_next = G_FINISH;
      end
      G_FINISH: state_next = G_IDLE;
      default:  state_next = G_IDLE;
    endcase
    if (start) begin
      state_next = G_DIVIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Divider datapath and result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= eff_size;
      size_hold <= eff_size;
      dvs       <= eff_grid;
      rem       <= '0;
      quo       <= '0;
      cnt       <= DIV_CNT_W'(SIZE_W - 1);
    end else if (state == G_DIVIDE) begin
      rem <= fits ? GRID_W'(rem_sh - {1'b0, dvs}) : rem_sh[GRID_W-1:0];
      quo <= {quo[SIZE_W-2:0], fits};
      dvd <= {dvd[SIZE_W-2:0], 1'b0};
      cnt <= cnt - DIV_CNT_W'(1);
    end
    if (state == G_FINISH && !start) begin
      cell_sz <= quo;
      crop_lo <= lo_next;
      crop_hi <= lo_next + crop;
      thr     <= thr_next;
    end
  end

  assign geom.busy    = start || (state != G_IDLE);
  assign geom.size    = size_hold;
  assign geom.grid    = dvs;
  assign geom.cell_sz = cell_sz;
  assign geom.crop_lo = crop_lo;
  assign geom.crop_hi = crop_hi;

endmodule

### design/grid_color_histogram.sv
// Top level of the grid color histogram: item pipeline, store and registers.
//
//   channel  direction  handshake            payload
//   input    in         in_valid, in_stall   operation, blue, green, red, column, row, read_bin
//   output   out        out_valid, out_stall bin_used, bin_count, counted
//   config   in/out     psel, penable, ...   image_size, grid_count
//
// An item goes through capture, store read, then modify and write back.
// The next item is taken once the store write is done, so items never overlap.
// After reset a clearing pass zeroes all 1024 store entries; items are stalled meanwhile.
// After each register write the crop geometry is recomputed.
// A stalled result holds the input off until it is taken.
`include "grid_color_histogram_assert.svh"

module grid_color_histogram import gch_pkg::*; #(
  parameter int LEVELS   = LEVELS_DEFAULT,
  parameter int MAX_GRID = MAX_GRID_DEFAULT,
  parameter int MAX_SIZE = MAX_SIZE_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input items.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            operation,
  input  logic [7:0]            blue,
  input  logic [7:0]            green,
  input  logic [7:0]            red,
  input  logic [7:0]            column,
  input  logic [7:0]            row,
  input  logic [BIN_W-1:0]      read_bin,
  // Result items.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BIN_W-1:0]      bin_used,
  output logic [COUNT_W-1:0]    bin_count,
  output logic                  counted,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int LB      = $clog2(LEVELS);
  localparam int CNT_W   = $clog2(MAX_GRID + 1);
  localparam int CELL_W  = (MAX_GRID > 1) ? $clog2(MAX_GRID * MAX_GRID) : 1;
  localparam int WIDE_W  = CELL_W + 3 * LB;
  localparam int ADDR_W  = $clog2(STORE_DEPTH);

  // Configuration registers.
  logic [SIZE_W-1:0]     image_size;
  logic [GRID_REG_W-1:0] grid_count;
  logic                  cfg_write;
  logic                  cfg_written;

  // Geometry.
  geom_t             geom;
  logic [SIZE_W-1:0] thr [MAX_GRID];

  // Clearing pass.
  logic              clearing;
  logic [ADDR_W-1:0] clear_addr;

  // Pipeline stages.
  logic              in_take;
  logic              a_valid;
  logic [1:0]        a_op;
  logic [7:0]        a_blue;
  logic [7:0]        a_green;
  logic [7:0]        a_red;
  logic [7:0]        a_column;
  logic [7:0]        a_row;
  logic [BIN_W-1:0]  a_read_bin;
  logic              b_valid;
  logic              b_acc;
  logic              b_clear;
  logic              b_ok;
  logic [BIN_W-1:0]  b_bin;

  // Bin computation.
  logic [SIZE_W-1:0] col9;
  logic [SIZE_W-1:0] row9;
  logic [SIZE_W-1:0] off_col;
  logic [SIZE_W-1:0] off_row;
  logic              in_crop;
  logic [CNT_W-1:0]  ncol;
  logic [CNT_W-1:0]  nrow;
  logic [CELL_W-1:0] cell_num;
  logic [WIDE_W-1:0] wide_bin;
  logic [31:0]       wide32;
  logic              acc_ok;
  logic [BIN_W-1:0]  acc_bin;
  logic [BIN_W-1:0]  a_bin;

  // Store ports.
  logic               st_we;
  logic [ADDR_W-1:0]  st_waddr;
  logic [COUNT_W-1:0] st_wdata;
  logic [COUNT_W-1:0] st_rdata;
  logic [COUNT_W-1:0] incr;

  // Configuration writes and reads.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size  <= IMAGE_SIZE_RESET;
      grid_count  <= GRID_COUNT_RESET;
      cfg_written <= 1'b1;
    end else begin
      cfg_written <= cfg_write;
      if (cfg_write) begin
        case (paddr[2])
          REG_IMAGE_SIZE: image_size <= pwdata[SIZE_W-1:0];
          REG_GRID_COUNT: grid_count <= pwdata[GRID_REG_W-1:0];
          default:        image_size <= image_size;
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_SIZE: prdata = APB_DATA_W'(image_size);
      REG_GRID_COUNT: prdata = APB_DATA_W'(grid_count);
      default:        prdata = '0;
    endcase
  end

  gch_geom #(
    .MAX_GRID (MAX_GRID),
    .MAX_SIZE (MAX_SIZE)
  ) u_geom (
    .clk        (clk),
    .rst        (rst),
    .start      (cfg_written),
    .image_size (image_size),
    .grid_count (grid_count),
    .geom       (geom),
    .thr        (thr)
  );

  // Clearing pass over the store after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + ADDR_W'(1);
      if (clear_addr == ADDR_W'(STORE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // One item at a time; a waiting result holds the input off.
  assign in_stall = clearing || geom.busy || a_valid || b_valid || (out_valid && out_stall);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_op       <= operation;
      a_blue     <= blue;
      a_green    <= green;
      a_red      <= red;
      a_column   <= column;
      a_row      <= row;
      a_read_bin <= read_bin;
    end
  end

  // Crop test and cell index from the column and row.
  assign col9    = SIZE_W'(a_column);
  assign row9    = SIZE_W'(a_row);
  assign off_col = col9 - geom.crop_lo;
  assign off_row = row9 - geom.crop_lo;
  assign in_crop = (geom.cell_sz != '0)
                && (col9 >= geom.crop_lo) && (col9 < geom.crop_hi) && (col9 < geom.size)
                && (row9 >= geom.crop_lo) && (row9 < geom.crop_hi) && (row9 < geom.size);

  always_comb begin
    ncol = '0;
    nrow = '0;
    for (int k = 0; k < MAX_GRID; k++) begin
      if (off_col >= thr[k]) begin
        ncol = ncol + CNT_W'(1);
      end
      if (off_row >= thr[k]) begin
        nrow = nrow + CNT_W'(1);
      end
    end
  end

  // Cell number and color index packed into the bin.
  assign cell_num = CELL_W'((nrow - CNT_W'(1)) * geom.grid) + CELL_W'(ncol - CNT_W'(1));
  assign wide_bin = {cell_num, a_blue[7 -: LB], a_green[7 -: LB], a_red[7 -: LB]};
  assign wide32   = 32'(wide_bin);
  assign acc_ok   = in_crop && (wide32 < 32'(STORE_DEPTH));
  assign acc_bin  = wide32[BIN_W-1:0];
  assign a_bin    = (a_op == OP_ACCUMULATE) ? acc_bin : a_read_bin;

  always_ff @(posedge clk) begin
    if (a_valid) begin
      b_acc   <= (a_op == OP_ACCUMULATE);
      b_clear <= (a_op == OP_READ_CLEAR);
      b_ok    <= (a_op == OP_ACCUMULATE) ? acc_ok : 1'b1;
      b_bin   <= a_bin;
    end
  end

  // Stage valid flags and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid <= in_take;
      b_valid <= a_valid;
      if (b_valid) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Saturating increment of the stored count.
  assign incr = (st_rdata < BIN_MAX) ? st_rdata + COUNT_W'(1) : st_rdata;

  always_ff @(posedge clk) begin
    if (b_valid) begin
      if (b_acc) begin
        bin_used  <= b_ok ? b_bin : '0;
        bin_count <= b_ok ? incr : '0;
        counted   <= b_ok;
      end else begin
        bin_used  <= b_bin;
        bin_count <= st_rdata;
        counted   <= 1'b0;
      end
    end
  end

  // Store write port: clearing pass, else the write-back of stage B.
  always_comb begin
    if (clearing) begin
      st_we    = 1'b1;
      st_waddr = clear_addr;
      st_wdata = '0;
    end else begin
      st_we    = b_valid && ((b_acc && b_ok) || b_clear);
      st_waddr = b_bin;
      st_wdata = b_acc ? incr : '0;
    end
  end

  gch_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (a_bin),
    .rdata (st_rdata)
  );

  // Checks on the pipeline interlock and the results.
  `GCH_ASSERT_NOW(a_wb_not_clearing, b_valid, !clearing, "write-back during clearing pass")
  `GCH_ASSERT_NOW(a_out_free, b_valid, !out_valid, "result overwrites a waiting result")
  `GCH_ASSERT_NEXT(a_stage_flow, a_valid, b_valid && !a_valid, "item lost between stages")
  `GCH_ASSERT_NOW(a_counted_nonzero, out_valid && counted, bin_count != '0, "counted bin is zero")

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the grid color histogram with a bin count scoreboard.
module testbench;
  import gch_pkg::*;

  localparam real        CLK_PERIOD     = 12.0;
  localparam int         RESET_CYCLES   = 7;
  localparam int         RANDOM_PHASES  = 8;
  localparam int         PHASE_ITEMS    = 200;
  localparam int         BURST_ITEMS    = 100;
  localparam int         SETTLE_CYCLES  = 10;
  localparam int         MAX_GAP        = 4;
  localparam int         LEVEL_DIV      = 256 / LEVELS_DEFAULT;
  // Operation code three has no name in the package and behaves as a plain read.
  localparam logic [1:0] OP_READ_ALIAS  = 2'd3;

  // One result item as the block should present it.
  typedef struct packed {
    logic [BIN_W-1:0]   bin;
    logic [COUNT_W-1:0] count;
    logic               hit;
  } bin_result_t;

  // Shadow of the histogram store and registers, with the queue of pending results.
  class histogram_scoreboard;
    logic [COUNT_W-1:0]    counts [STORE_DEPTH];
    logic [SIZE_W-1:0]     image_size;
    logic [GRID_REG_W-1:0] grid_count;
    bin_result_t           pending_q [$];
    logic [BIN_W-1:0]      last_bin;
    int errors;
    int items_seen;
    int pixels_counted;
    int reads_seen;
    int full_bin_hits;

    function void clear();
      foreach (counts[i]) counts[i] = '0;
      image_size = IMAGE_SIZE_RESET;
      grid_count = GRID_COUNT_RESET;
      last_bin   = '0;
    endfunction

    function int grid_eff();
      if (grid_count == 0) return 1;
      if (grid_count > MAX_GRID_DEFAULT) return MAX_GRID_DEFAULT;
      return int'(grid_count);
    endfunction

    function int size_eff();
      return (image_size > MAX_SIZE_DEFAULT) ? MAX_SIZE_DEFAULT : int'(image_size);
    endfunction

    function void write_register(logic idx, logic [APB_DATA_W-1:0] value);
      if (idx == REG_IMAGE_SIZE) image_size = value[SIZE_W-1:0];
      else grid_count = value[GRID_REG_W-1:0];
    endfunction

    function logic [APB_DATA_W-1:0] register_value(logic idx);
      if (idx == REG_IMAGE_SIZE) return APB_DATA_W'(image_size);
      return APB_DATA_W'(grid_count);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Works out the result of one accepted item and updates the shadow store.
    function void note_input(logic [1:0] op, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                             logic [7:0] col, logic [7:0] row, logic [BIN_W-1:0] rbin);
      int n, sz, cell_sz, crop, start, x, y, cell_idx, color, bin_idx;
      bin_result_t res;
      res = '0;
      items_seen++;
      if (op == OP_ACCUMULATE) begin
        n       = grid_eff();
        sz      = size_eff();
        cell_sz = sz / n;
        crop    = cell_sz * n;
        start   = (sz - crop) / 2;
        x       = int'(col);
        y       = int'(row);
        if (cell_sz != 0 && x >= start && x < start + crop && x < sz &&
            y >= start && y < start + crop && y < sz) begin
          cell_idx = ((y - start) / cell_sz) * n + (x - start) / cell_sz;
          color    = (int'(b) / LEVEL_DIV) * LEVELS_DEFAULT * LEVELS_DEFAULT +
                     (int'(g) / LEVEL_DIV) * LEVELS_DEFAULT + int'(r) / LEVEL_DIV;
          bin_idx  = cell_idx * LEVELS_DEFAULT * LEVELS_DEFAULT * LEVELS_DEFAULT + color;
          // A bin past the end of the store is dropped like a pixel off the crop.
          if (bin_idx < STORE_DEPTH) begin
            if (counts[bin_idx] < BIN_MAX) counts[bin_idx]++;
            else full_bin_hits++;
            res.bin   = BIN_W'(bin_idx);
            res.count = counts[bin_idx];
            res.hit   = 1'b1;
            last_bin  = BIN_W'(bin_idx);
            pixels_counted++;
          end
        end
      end else begin
        reads_seen++;
        res.bin   = rbin;
        res.count = counts[rbin];
        if (op == OP_READ_CLEAR) counts[rbin] = '0;
      end
      pending_q = {pending_q, res};
    endfunction

    // Compares one accepted result with the oldest pending one.
    task check_result(logic [BIN_W-1:0] bin, logic [COUNT_W-1:0] count, logic hit);
      bin_result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("result with nothing pending: bin %0d count %0d", bin, count));
        return;
      end
      want = pending_q.pop_front();
      if (bin !== want.bin)
        report($sformatf("bin_used %0d, expected %0d", bin, want.bin));
      if (count !== want.count)
        report($sformatf("bin_count %0d for bin %0d, expected %0d", count, want.bin, want.count));
      if (hit !== want.hit)
        report($sformatf("counted %0b for bin %0d, expected %0b", hit, want.bin, want.hit));
    endtask
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [1:0]            operation = OP_ACCUMULATE;
  logic [7:0]            blue      = '0;
  logic [7:0]            green     = '0;
  logic [7:0]            red       = '0;
  logic [7:0]            column    = '0;
  logic [7:0]            row       = '0;
  logic [BIN_W-1:0]      read_bin  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BIN_W-1:0]      bin_used;
  logic [COUNT_W-1:0]    bin_count;
  logic                  counted;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  histogram_scoreboard sb;
  bit gaps_on = 1'b1;
  int register_writes;

  grid_color_histogram uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .blue      (blue),
    .green     (green),
    .red       (red),
    .column    (column),
    .row       (row),
    .read_bin  (read_bin),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bin_used  (bin_used),
    .bin_count (bin_count),
    .counted   (counted),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watch both channels; every accepted item and result goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_input(operation, blue, green, red, column, row, read_bin);
    if (!rst && out_valid && !out_stall)
      sb.check_result(bin_used, bin_count, counted);
  end

  // Result side: a random stall before each result, none while gaps are off.
  initial begin
    int hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one item after a random gap and waits until it is taken.
  task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic [7:0] g,
                           input logic [7:0] r, input logic [7:0] col, input logic [7:0] rw,
                           input logic [BIN_W-1:0] rbin);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    blue      <= b;
    green     <= g;
    red       <= r;
    column    <= col;
    row       <= rw;
    read_bin  <= rbin;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                       input logic [7:0] col, input logic [7:0] rw);
    send_item(OP_ACCUMULATE, b, g, r, col, rw, BIN_W'($urandom));
  endtask

  task automatic read_item(input logic [1:0] op, input logic [BIN_W-1:0] rbin);
    send_item(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), rbin);
  endtask

  // Stops sending and waits until every pending result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    // The item taken at the last edge is noted by the monitor before this check.
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // One transfer on the register port: setup cycle, then access until ready.
  task automatic reg_access(input bit is_write, input logic idx,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes a register with the block idle, then reads it back.
  task automatic set_register(input logic idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] rd;
    drain();
    reg_access(1'b1, idx, value, rd);
    sb.write_register(idx, value);
    register_writes++;
    reg_access(1'b0, idx, '0, rd);
    if (rd !== sb.register_value(idx))
      sb.report($sformatf("register %0d read back %0h, expected %0h",
                          idx, rd, sb.register_value(idx)));
  endtask

  // Mostly pixels on the image with random colors, plus reads and raw noise.
  task automatic random_item();
    int pick, lim;
    logic [7:0] col, rw;
    pick = $urandom_range(0, 99);
    lim  = sb.size_eff();
    if (pick < 70) begin
      col = (lim > 0) ? 8'($urandom_range(0, lim - 1)) : 8'($urandom);
      rw  = (lim > 0) ? 8'($urandom_range(0, lim - 1)) : 8'($urandom);
      pixel(8'($urandom), 8'($urandom), 8'($urandom), col, rw);
    end else if (pick < 85) begin
      read_item(2'($urandom_range(OP_READ, OP_READ_ALIAS)), sb.last_bin);
    end else if (pick < 93) begin
      read_item(2'($urandom_range(OP_READ, OP_READ_ALIAS)), BIN_W'($urandom));
    end else begin
      send_item(2'($urandom_range(OP_ACCUMULATE, OP_READ_ALIAS)), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), 8'($urandom), BIN_W'($urandom));
    end
  endtask

  // Run limit, far beyond the slowest correct run.
  initial begin
    #(CLK_PERIOD * 3000000);
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    int phase_size [RANDOM_PHASES] = '{256, 64, 1, 511, 200, 17, 100, 0};
    int phase_grid [RANDOM_PHASES] = '{4, 1, 1, 7, 3, 2, 4, 0};
    sb = new;
    sb.clear();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Default 64 pixel image in one cell: corners, channel extremes, pixels off the image.
    pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0);
    pixel(8'd0, 8'd0, 8'd0, 8'd63, 8'd63);
    pixel(8'h40, 8'h80, 8'hC0, 8'd31, 8'd32);
    pixel(8'h7F, 8'hBF, 8'hFF, 8'd31, 8'd32);
    pixel(8'h7F, 8'hBF, 8'hFF, 8'd1, 8'd2);
    pixel(8'd0, 8'd0, 8'd0, 8'd64, 8'd0);
    pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd64);
    pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    read_item(OP_READ, 10'd63);
    read_item(OP_READ_CLEAR, 10'd63);
    read_item(OP_READ, 10'd63);
    read_item(OP_READ_ALIAS, 10'd0);
    read_item(OP_READ, 10'd1023);
    read_item(OP_READ_CLEAR, 10'd0);

    // Four by four grid over a 255 pixel image: the crop starts one pixel in.
    set_register(REG_GRID_COUNT, 32'd4);
    set_register(REG_IMAGE_SIZE, 32'd255);
    pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd100);
    pixel(8'd255, 8'd255, 8'd255, 8'd1, 8'd1);
    pixel(8'd255, 8'd255, 8'd255, 8'd252, 8'd252);
    pixel(8'd255, 8'd255, 8'd255, 8'd253, 8'd10);
    read_item(OP_READ, 10'd1023);

    // Out of range registers clamp: grid seven acts as four, size 511 as 256.
    set_register(REG_GRID_COUNT, 32'd7);
    set_register(REG_IMAGE_SIZE, 32'd511);
    pixel(8'd255, 8'd0, 8'd128, 8'd255, 8'd255);

    // Empty crops: image smaller than the grid, then size zero with grid zero.
    set_register(REG_IMAGE_SIZE, 32'd3);
    pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    set_register(REG_IMAGE_SIZE, 32'd0);
    set_register(REG_GRID_COUNT, 32'd0);
    pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);

    // One bin hit again and again at full rate on both sides.
    set_register(REG_IMAGE_SIZE, 32'd1);
    set_register(REG_GRID_COUNT, 32'd1);
    gaps_on = 1'b0;
    read_item(OP_READ_CLEAR, 10'd0);
    repeat (BURST_ITEMS)
      pixel(8'($urandom_range(0, LEVEL_DIV - 1)), 8'($urandom_range(0, LEVEL_DIV - 1)),
            8'($urandom_range(0, LEVEL_DIV - 1)), 8'd0, 8'd0);
    read_item(OP_READ_CLEAR, 10'd0);
    read_item(OP_READ, 10'd0);
    gaps_on = 1'b1;

    // Random phases, each under its own register setting; the last two are random.
    phase_size[6] = $urandom_range(0, 511);
    phase_grid[6] = $urandom_range(0, 7);
    phase_size[7] = $urandom_range(0, 511);
    phase_grid[7] = $urandom_range(0, 7);
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_register(REG_IMAGE_SIZE, phase_size[p]);
      set_register(REG_GRID_COUNT, phase_grid[p]);
      gaps_on = (p != 1) && ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) random_item();
    end
    gaps_on = 1'b1;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d items: %0d pixels counted, %0d reads, %0d hits on a full bin.",
             sb.items_seen, sb.pixels_counted, sb.reads_seen, sb.full_bin_hits);
    $display("Register writes: %0d, mismatches: %0d.", register_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
